FILE: hw/rtl/gabc_pkg.sv
// ----------------------------------------------------------------------------
// gabc_pkg: shared constants, types and helpers
// Q4.28 arithmetic helpers, sizes of the state memory and the sine table.
// ----------------------------------------------------------------------------
package gabc_pkg;

    localparam int MAX_POLES      = 20;
    localparam int BAND_COUNT     = 9;
    localparam int MAX_SPK        = 35;
    localparam int SAMPLE_BITS    = 24;
    localparam int SAMPLE_RATE_HZ = 48000;
    localparam int SINE_POINTS    = 257;

    // State memory layout: band sections, then lowpass stages, then highpass stages.
    localparam int LOW_BASE  = MAX_POLES * BAND_COUNT;
    localparam int HIGH_BASE = LOW_BASE + MAX_SPK;
    localparam int MEM_DEPTH = HIGH_BASE + MAX_SPK;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    typedef logic signed [31:0] q_t;
    typedef q_t sine_tab_t [SINE_POINTS];

    localparam q_t Q_ONE     = 32'sd268435456;
    localparam q_t Q_HALF    = 32'sd134217728;
    localparam q_t Q_GOLDEN  = 32'sd165902236;
    localparam q_t Q_CENTI   = 32'sd2684355;
    localparam q_t Q_INT_MAX = 32'sh7FFFFFFF;
    localparam q_t Q_INT_MIN = 32'sh80000000;
    // Turn scale minus 2^31; the 2^31 part is added as a shift.
    localparam q_t TURN_LO   = 32'sd586777454;
    localparam longint FR0_L = (longint'(39690) <<< 28) / SAMPLE_RATE_HZ;
    localparam q_t Q_FR0     = q_t'(FR0_L);
    localparam logic signed [35:0] CBAL_CAP = 36'sd26843545600;

    typedef enum logic [2:0] {
        CFG_POLES    = 3'd0,
        CFG_PRESENCE = 3'd1,
        CFG_HIGH     = 3'd2,
        CFG_MID      = 3'd3,
        CFG_LOW      = 3'd4,
        CFG_SUB      = 3'd5,
        CFG_SPEAKER  = 3'd6,
        CFG_RATE     = 3'd7
    } cfg_idx_t;

    function automatic q_t sat64(input logic signed [63:0] v);
        q_t r;
        if (v > 64'sd2147483647)
            r = Q_INT_MAX;
        else if (v < -64'sd2147483648)
            r = Q_INT_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic q_t sat33(input logic signed [32:0] v);
        q_t r;
        if (v[32] != v[31])
            r = v[32] ? Q_INT_MIN : Q_INT_MAX;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic q_t qadd(input q_t a, input q_t b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        return sat33(s);
    endfunction

    function automatic q_t qsub(input q_t a, input q_t b);
        logic signed [32:0] s;
        s = {a[31], a} - {b[31], b};
        return sat33(s);
    endfunction

    function automatic q_t qabs(input q_t a);
        logic signed [32:0] s;
        s = -{a[31], a};
        return a[31] ? sat33(s) : a;
    endfunction

    // Round half up and saturate a raw Q8.56 product back to Q4.28.
    function automatic q_t qround(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = (p + 64'sd134217728) >>> 28;
        return sat64(s);
    endfunction

    // Quarter-wave sine points, evaluated at elaboration.
    function automatic sine_tab_t build_sine();
        sine_tab_t tab;
        logic signed [63:0] a;
        logic signed [63:0] x2;
        logic signed [63:0] p;
        logic signed [63:0] s;
        logic signed [63:0] one;
        for (int k = 0; k < SINE_POINTS; k++)
        begin
            one = 64'sd268435456;
            a   = 64'(k) * 64'sd1647099;
            x2  = (a * a + 64'sd134217728) >>> 28;
            p   = one - x2 / 110;
            p   = one - ((x2 * p + 64'sd134217728) >>> 28) / 72;
            p   = one - ((x2 * p + 64'sd134217728) >>> 28) / 42;
            p   = one - ((x2 * p + 64'sd134217728) >>> 28) / 20;
            p   = one - ((x2 * p + 64'sd134217728) >>> 28) / 6;
            s   = (a * p + 64'sd134217728) >>> 28;
            if (s < 0)
                s = 0;
            if (s > one)
                s = one;
            tab[k] = s[31:0];
        end
        return tab;
    endfunction

endpackage

FILE: hw/rtl/guitar_amp_band_compressor_core.sv
// ----------------------------------------------------------------------------
// guitar_amp_band_compressor_core
// Band-split compressor poles, sine saturator, speaker filters and output gain.
// ----------------------------------------------------------------------------
// The block takes one 24-bit sample item and returns one 24-bit result item.
// It handles one item at a time: s_tready is high only while the sequencer is
// idle, and the finished result sits in an output register so the next item
// can be taken while the result still waits for m_tready. Every multiply runs
// through a single 32x32 multiplier, one multiply per cycle, and every filter
// state lives in one 250-entry memory of {slope, level} pairs that is read,
// updated and written back one section at a time. The pole count in use is at
// most 20, the lowpass chain has 3 + ceil(lowpass coef / 2048) sections and
// the highpass chain the same for its coefficient. At the start of every item,
// a bit-serial divider computes the speaker compensation reciprocal. The
// memory needs no clearing pass: per-entry valid bits, cleared by reset, make
// unwritten entries read as zero. Configuration writes are taken at any time
// but must only be made while the block is idle.
// ----------------------------------------------------------------------------
module guitar_amp_band_compressor_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] sample_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [23:0] sample_out
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [35:0] {
        ST_IDLE = 36'd1 << 0,
        ST_DIV  = 36'd1 << 1,
        ST_RD   = 36'd1 << 2,
        ST_PA   = 36'd1 << 3,
        ST_PB   = 36'd1 << 4,
        ST_PC   = 36'd1 << 5,
        ST_PD   = 36'd1 << 6,
        ST_PE   = 36'd1 << 7,
        ST_PF   = 36'd1 << 8,
        ST_PG   = 36'd1 << 9,
        ST_B1   = 36'd1 << 10,
        ST_B2   = 36'd1 << 11,
        ST_B3   = 36'd1 << 12,
        ST_B4   = 36'd1 << 13,
        ST_B5   = 36'd1 << 14,
        ST_B6   = 36'd1 << 15,
        ST_B7   = 36'd1 << 16,
        ST_B8   = 36'd1 << 17,
        ST_B9   = 36'd1 << 18,
        ST_B10  = 36'd1 << 19,
        ST_B11  = 36'd1 << 20,
        ST_B12  = 36'd1 << 21,
        ST_B13  = 36'd1 << 22,
        ST_B14  = 36'd1 << 23,
        ST_B15  = 36'd1 << 24,
        ST_B16  = 36'd1 << 25,
        ST_R1   = 36'd1 << 26,
        ST_R2   = 36'd1 << 27,
        ST_S1   = 36'd1 << 28,
        ST_S2   = 36'd1 << 29,
        ST_S3   = 36'd1 << 30,
        ST_S4   = 36'd1 << 31,
        ST_L1   = 36'd1 << 32,
        ST_L2   = 36'd1 << 33,
        ST_O1   = 36'd1 << 34,
        ST_O2   = 36'd1 << 35
    } state_t;

    typedef enum logic [1:0] {
        MODE_BAND = 2'd0,
        MODE_LOW  = 2'd1,
        MODE_HIGH = 2'd2
    } mode_t;

    localparam gabc_pkg::sine_tab_t SINE_TAB = gabc_pkg::build_sine();
    localparam int BAND_LAST = gabc_pkg::BAND_COUNT - 1;

    // Configuration registers.
    logic [4:0]  pole_count_reg;
    logic [16:0] gain_presence_reg, gain_high_reg, gain_mid_reg, gain_low_reg, gain_sub_reg;
    logic [31:0] speaker_coefs_reg, rate_and_level_reg;

    // Sequencer and datapath registers.
    state_t state_reg;
    mode_t  mode_reg;
    logic [4:0] poles_reg, x_reg;
    logic [3:0] y_reg;
    logic [5:0] i_reg, div_cnt_reg;
    logic [gabc_pkg::ADDR_W-1:0] addr_reg;
    logic [16:0] rem_reg;
    gabc_pkg::q_t inv_reg, acc_reg, pin_reg, fr_reg, a1_reg, slope_reg, out_reg;
    gabc_pkg::q_t ph_reg, cy_reg, omc_reg, cbl_reg, bal_reg, omd_reg, lo_reg;
    logic signed [35:0] cbal_reg;
    logic signed [63:0] prod_reg, p1_reg;
    logic [8:0]  idx_reg;
    logic [21:0] frac_reg;
    logic [1:0]  quad_reg;
    logic        out_valid_reg;
    logic [23:0] out_data_reg;

    // Envelope state, one entry per band.
    gabc_pkg::q_t env_phase_reg [gabc_pkg::BAND_COUNT];
    gabc_pkg::q_t env_accum_reg [gabc_pkg::BAND_COUNT];
    gabc_pkg::q_t env_ha_reg    [gabc_pkg::BAND_COUNT];
    gabc_pkg::q_t env_hb_reg    [gabc_pkg::BAND_COUNT];
    gabc_pkg::q_t env_hc_reg    [gabc_pkg::BAND_COUNT];

    // Filter state memory: {slope, level} per section.
    logic [63:0] mem [gabc_pkg::MEM_DEPTH];
    logic [63:0] mem_q;
    logic        vld_reg [gabc_pkg::MEM_DEPTH];
    logic        vld_q;

    // Combinational values.
    gabc_pkg::q_t mul_a, mul_b, mq, lf, hf, rez, level_gain, pf, pomf;
    gabc_pkg::q_t slope0, level0, a_plus_q, gsel, g9, in_q, acc_sum;
    gabc_pkg::q_t env_new, cy_new, omc_new, damp, sine_v, sine_res, l2_acc;
    logic [15:0] lc, hc;
    logic [5:0]  nl, nh, nl_raw, nh_raw;
    logic [16:0] divisor;
    logic [17:0] trial;
    logic        env_wrap;
    logic signed [33:0] term;
    logic signed [36:0] cbal_sum;
    logic signed [35:0] cbal_new;
    logic signed [63:0] tot, damp_w, ph64, sine_corr;
    logic [31:0] ph;
    logic [30:0] mpos;
    logic [8:0]  idx_hi;
    logic signed [32:0] out_round;
    logic signed [27:0] out_w;
    logic [23:0] out_sat;
    logic [17:0] gsum01, gsum23, gsum45, gsum67;

    assign lc = speaker_coefs_reg[15:0];
    assign hc = speaker_coefs_reg[31:16];
    assign lf = {4'b0, lc, 12'b0};
    assign hf = {4'b0, hc, 12'b0};
    assign rez = {4'b0, rate_and_level_reg[15:0], 12'b0};
    assign level_gain = {4'b0, rate_and_level_reg[31:16], 12'b0};
    assign nl_raw = 6'd3 + 6'((17'(lc) + 17'd2047) >> 11);
    assign nh_raw = 6'd3 + 6'((17'(hc) + 17'd2047) >> 11);
    assign nl = (nl_raw > 6'(gabc_pkg::MAX_SPK)) ? 6'(gabc_pkg::MAX_SPK) : nl_raw;
    assign nh = (nh_raw > 6'(gabc_pkg::MAX_SPK)) ? 6'(gabc_pkg::MAX_SPK) : nh_raw;
    assign divisor = 17'd6144 + 17'(lc);
    assign trial = {rem_reg, (div_cnt_reg == 6'd39)};

    assign mq = gabc_pkg::qround(prod_reg);
    assign in_q = {{3{s_tdata[23]}}, s_tdata, 5'b0};

    // Filter coefficient of the section being worked on.
    always_comb
    begin
        case (mode_reg)
            MODE_LOW:  pf = lf;
            MODE_HIGH: pf = hf;
            default:   pf = fr_reg;
        endcase
    end
    assign pomf = gabc_pkg::qsub(gabc_pkg::Q_ONE, pf);

    assign slope0 = vld_q ? mem_q[63:32] : '0;
    assign level0 = vld_q ? mem_q[31:0] : '0;
    assign a_plus_q = gabc_pkg::qadd(a1_reg, mq);
    assign acc_sum = gabc_pkg::qadd(acc_reg, mq);
    assign l2_acc = gabc_pkg::qsub(acc_reg, mq);

    // Band gains: odd bands take the mean of their neighbors.
    assign gsum01 = 18'(gain_presence_reg) + 18'(gain_high_reg);
    assign gsum23 = 18'(gain_high_reg) + 18'(gain_mid_reg);
    assign gsum45 = 18'(gain_mid_reg) + 18'(gain_low_reg);
    assign gsum67 = 18'(gain_low_reg) + 18'(gain_sub_reg);
    assign g9 = {3'b0, gain_sub_reg, 12'b0};
    always_comb
    begin
        case (y_reg)
            4'd0:    gsel = {3'b0, gain_presence_reg, 12'b0};
            4'd1:    gsel = {3'b0, gsum01[17:1], 12'b0};
            4'd2:    gsel = {3'b0, gain_high_reg, 12'b0};
            4'd3:    gsel = {3'b0, gsum23[17:1], 12'b0};
            4'd4:    gsel = {3'b0, gain_mid_reg, 12'b0};
            4'd5:    gsel = {3'b0, gsum45[17:1], 12'b0};
            4'd6:    gsel = {3'b0, gain_low_reg, 12'b0};
            4'd7:    gsel = {3'b0, gsum67[17:1], 12'b0};
            default: gsel = g9;
        endcase
    end

    // Envelope update: the accumulator is pushed into the history on wrap.
    assign env_new  = gabc_pkg::qadd(env_accum_reg[y_reg], mq);
    assign env_wrap = ph_reg > gabc_pkg::Q_ONE;
    assign cy_new   = env_wrap ? (ph_reg - gabc_pkg::Q_ONE) : ph_reg;
    assign omc_new  = gabc_pkg::qsub(gabc_pkg::Q_ONE, cy_new);

    // Compression sum, held within plus and minus 100.
    assign term = 34'(env_hb_reg[y_reg]) + 34'(a_plus_q);
    assign cbal_sum = 37'(cbal_reg) + 37'(term >>> 1);
    always_comb
    begin
        if (cbal_sum > 37'(gabc_pkg::CBAL_CAP))
            cbal_new = gabc_pkg::CBAL_CAP;
        else if (cbal_sum < -37'(gabc_pkg::CBAL_CAP))
            cbal_new = -gabc_pkg::CBAL_CAP;
        else
            cbal_new = cbal_sum[35:0];
    end

    // Damping from the two partial products of sum * 0.01.
    assign tot    = (prod_reg <<< 16) + p1_reg + 64'sd134217728;
    assign damp_w = tot >>> 28;
    always_comb
    begin
        if (damp_w > 64'(gabc_pkg::Q_ONE))
            damp = gabc_pkg::Q_ONE;
        else
            damp = gabc_pkg::sat64(damp_w);
    end

    // Sine phase: x * turn scale >> 30, taken as a 32-bit turn.
    assign ph64 = (64'(acc_reg) <<< 31) + prod_reg;
    assign ph   = ph64[61:30];
    assign mpos = ph[30] ? (31'h40000000 - {1'b0, ph[29:0]}) : {1'b0, ph[29:0]};
    assign idx_hi = (idx_reg == 9'd256) ? 9'd256 : (idx_reg + 9'd1);
    assign sine_corr = (prod_reg + 64'sd2097152) >>> 22;
    assign sine_v = lo_reg + sine_corr[31:0];
    assign sine_res = quad_reg[1] ? -sine_v : sine_v;

    // Output rounding and saturation to 24 bits.
    assign out_round = 33'(mq) + 33'sd16;
    assign out_w = out_round[32:5];
    always_comb
    begin
        if (out_w > 28'sd8388607)
            out_sat = 24'h7FFFFF;
        else if (out_w < -28'sd8388608)
            out_sat = 24'h800000;
        else
            out_sat = out_w[23:0];
    end

    // Multiplier operand selection, one product per state.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_PA:
            begin
                mul_a = slope0;
                mul_b = pomf;
            end
            ST_PB:
            begin
                mul_a = gabc_pkg::qsub(pin_reg, level0);
                mul_b = pf;
            end
            ST_PC, ST_PF:
            begin
                mul_a = a_plus_q;
                mul_b = pf;
            end
            ST_PD:
            begin
                mul_a = gabc_pkg::qadd(level0, mq);
                mul_b = pomf;
            end
            ST_PE:
            begin
                mul_a = pin_reg;
                mul_b = pf;
            end
            ST_B1:
            begin
                mul_a = gabc_pkg::qsub(pin_reg, out_reg);
                mul_b = gsel;
            end
            ST_B2:
            begin
                mul_a = fr_reg;
                mul_b = gabc_pkg::Q_GOLDEN;
            end
            ST_B3:
            begin
                mul_a = gabc_pkg::qabs(acc_reg);
                mul_b = rez;
            end
            ST_B5:
            begin
                mul_a = env_hc_reg[y_reg];
                mul_b = omc_reg;
            end
            ST_B6:
            begin
                mul_a = env_hb_reg[y_reg];
                mul_b = cy_reg;
            end
            ST_B7:
            begin
                mul_a = env_hb_reg[y_reg];
                mul_b = omc_reg;
            end
            ST_B8:
            begin
                mul_a = env_ha_reg[y_reg];
                mul_b = cy_reg;
            end
            ST_B9:
            begin
                mul_a = cbl_reg;
                mul_b = omc_reg;
            end
            ST_B10:
            begin
                mul_a = bal_reg;
                mul_b = cy_reg;
            end
            ST_B12:
            begin
                mul_a = {16'b0, cbal_reg[15:0]};
                mul_b = gabc_pkg::Q_CENTI;
            end
            ST_B13:
            begin
                mul_a = {{12{cbal_reg[35]}}, cbal_reg[35:16]};
                mul_b = gabc_pkg::Q_CENTI;
            end
            ST_B15:
            begin
                mul_a = acc_reg;
                mul_b = omd_reg;
            end
            ST_R1:
            begin
                mul_a = pin_reg;
                mul_b = g9;
            end
            ST_S1:
            begin
                mul_a = acc_reg;
                mul_b = gabc_pkg::TURN_LO;
            end
            ST_S3:
            begin
                mul_a = SINE_TAB[idx_hi] - SINE_TAB[idx_reg];
                mul_b = {10'b0, frac_reg};
            end
            ST_L1:
            begin
                mul_a = out_reg;
                mul_b = inv_reg;
            end
            ST_O1, ST_O2:
            begin
                mul_a = acc_reg;
                mul_b = level_gain;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    // State memory: one read and one write port, read data registered.
    always_ff @(posedge clk)
    begin
        mem_q <= mem[addr_reg];
        if (state_reg == ST_PG)
            mem[addr_reg] <= {slope_reg, a_plus_q};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_q <= 1'b0;
            for (int k = 0; k < gabc_pkg::MEM_DEPTH; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            vld_q <= vld_reg[addr_reg];
            if (state_reg == ST_PG)
                vld_reg[addr_reg] <= 1'b1;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_count_reg     <= 5'd5;
            gain_presence_reg  <= 17'd82897;
            gain_high_reg      <= 17'd77543;
            gain_mid_reg       <= 17'd65536;
            gain_low_reg       <= 17'd77543;
            gain_sub_reg       <= 17'd58617;
            speaker_coefs_reg  <= 32'h80000000;
            rate_and_level_reg <= 32'hFFFF0000;
        end
        else if (cfg_we)
        begin
            unique case (gabc_pkg::cfg_idx_t'(cfg_index))
                gabc_pkg::CFG_POLES:    pole_count_reg     <= cfg_data[4:0];
                gabc_pkg::CFG_PRESENCE: gain_presence_reg  <= cfg_data[16:0];
                gabc_pkg::CFG_HIGH:     gain_high_reg      <= cfg_data[16:0];
                gabc_pkg::CFG_MID:      gain_mid_reg       <= cfg_data[16:0];
                gabc_pkg::CFG_LOW:      gain_low_reg       <= cfg_data[16:0];
                gabc_pkg::CFG_SUB:      gain_sub_reg       <= cfg_data[16:0];
                gabc_pkg::CFG_SPEAKER:  speaker_coefs_reg  <= cfg_data;
                gabc_pkg::CFG_RATE:     rate_and_level_reg <= cfg_data;
                default:                pole_count_reg     <= pole_count_reg;
            endcase
        end
    end

    // Main sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_BAND;
            poles_reg     <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            i_reg         <= '0;
            div_cnt_reg   <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < gabc_pkg::BAND_COUNT; k++)
            begin
                env_phase_reg[k] <= gabc_pkg::Q_ONE;
                env_accum_reg[k] <= '0;
                env_ha_reg[k]    <= '0;
                env_hb_reg[k]    <= '0;
                env_hc_reg[k]    <= '0;
            end
        end
        else
        begin
            if (m_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        poles_reg <= (pole_count_reg > 5'(gabc_pkg::MAX_POLES)) ?
                                     5'(gabc_pkg::MAX_POLES) : pole_count_reg;
                        acc_reg   <= (pole_count_reg == 5'd0) ? in_q : '0;
                        pin_reg   <= in_q;
                        fr_reg    <= gabc_pkg::Q_FR0;
                        cbal_reg  <= '0;
                        x_reg     <= '0;
                        y_reg     <= '0;
                        addr_reg  <= '0;
                        mode_reg  <= MODE_BAND;
                        rem_reg   <= '0;
                        inv_reg   <= '0;
                        div_cnt_reg <= 6'd39;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    // Restoring division of 2^39 by 6144 + lc, one bit a cycle.
                    if (trial >= 18'(divisor))
                    begin
                        rem_reg <= 17'(trial - 18'(divisor));
                        inv_reg <= {inv_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial[16:0];
                        inv_reg <= {inv_reg[30:0], 1'b0};
                    end
                    div_cnt_reg <= div_cnt_reg - 6'd1;
                    if (div_cnt_reg == 6'd0)
                        state_reg <= (poles_reg != 5'd0) ? ST_RD : ST_S1;
                end
                ST_RD: state_reg <= ST_PA;
                ST_PA: state_reg <= ST_PB;
                ST_PB:
                begin
                    a1_reg    <= mq;
                    state_reg <= ST_PC;
                end
                ST_PC:
                begin
                    slope_reg <= a_plus_q;
                    state_reg <= ST_PD;
                end
                ST_PD: state_reg <= ST_PE;
                ST_PE:
                begin
                    a1_reg    <= mq;
                    state_reg <= ST_PF;
                end
                ST_PF:
                begin
                    out_reg   <= a_plus_q;
                    state_reg <= ST_PG;
                end
                ST_PG:
                begin
                    // Section state is written back this cycle.
                    case (mode_reg)
                        MODE_LOW:  state_reg <= ST_L1;
                        MODE_HIGH:
                        begin
                            acc_reg <= out_reg;
                            pin_reg <= out_reg;
                            if (i_reg + 6'd1 == nh)
                                state_reg <= ST_O1;
                            else
                            begin
                                i_reg     <= i_reg + 6'd1;
                                addr_reg  <= addr_reg + 1'b1;
                                state_reg <= ST_RD;
                            end
                        end
                        default:   state_reg <= ST_B1;
                    endcase
                end
                ST_B1:
                begin
                    pin_reg   <= out_reg;
                    state_reg <= ST_B2;
                end
                ST_B2:
                begin
                    acc_reg   <= acc_sum;
                    state_reg <= ST_B3;
                end
                ST_B3:
                begin
                    fr_reg    <= mq;
                    ph_reg    <= gabc_pkg::qadd(env_phase_reg[y_reg], rez);
                    state_reg <= ST_B4;
                end
                ST_B4:
                begin
                    env_phase_reg[y_reg] <= cy_new;
                    if (env_wrap)
                    begin
                        env_hc_reg[y_reg]    <= env_hb_reg[y_reg];
                        env_hb_reg[y_reg]    <= env_ha_reg[y_reg];
                        env_ha_reg[y_reg]    <= env_new;
                        env_accum_reg[y_reg] <= '0;
                    end
                    else
                        env_accum_reg[y_reg] <= env_new;
                    cy_reg    <= cy_new;
                    omc_reg   <= omc_new;
                    state_reg <= ST_B5;
                end
                ST_B5: state_reg <= ST_B6;
                ST_B6:
                begin
                    a1_reg    <= mq;
                    state_reg <= ST_B7;
                end
                ST_B7:
                begin
                    cbl_reg   <= a_plus_q;
                    state_reg <= ST_B8;
                end
                ST_B8:
                begin
                    a1_reg    <= mq;
                    state_reg <= ST_B9;
                end
                ST_B9:
                begin
                    bal_reg   <= a_plus_q;
                    state_reg <= ST_B10;
                end
                ST_B10:
                begin
                    a1_reg    <= mq;
                    state_reg <= ST_B11;
                end
                ST_B11:
                begin
                    cbal_reg  <= cbal_new;
                    state_reg <= ST_B12;
                end
                ST_B12: state_reg <= ST_B13;
                ST_B13:
                begin
                    p1_reg    <= prod_reg;
                    state_reg <= ST_B14;
                end
                ST_B14:
                begin
                    omd_reg   <= gabc_pkg::qsub(gabc_pkg::Q_ONE, damp);
                    state_reg <= ST_B15;
                end
                ST_B15: state_reg <= ST_B16;
                ST_B16:
                begin
                    acc_reg <= mq;
                    if (y_reg == 4'(BAND_LAST))
                        state_reg <= ST_R1;
                    else
                    begin
                        y_reg     <= y_reg + 4'd1;
                        addr_reg  <= addr_reg + 1'b1;
                        state_reg <= ST_RD;
                    end
                end
                ST_R1: state_reg <= ST_R2;
                ST_R2:
                begin
                    // The residual closes the pole; its sum feeds the next one.
                    if (x_reg + 5'd1 == poles_reg)
                    begin
                        acc_reg   <= acc_sum;
                        state_reg <= ST_S1;
                    end
                    else
                    begin
                        x_reg     <= x_reg + 5'd1;
                        y_reg     <= '0;
                        addr_reg  <= addr_reg + 1'b1;
                        pin_reg   <= acc_sum;
                        acc_reg   <= '0;
                        fr_reg    <= gabc_pkg::Q_FR0;
                        state_reg <= ST_RD;
                    end
                end
                ST_S1: state_reg <= ST_S2;
                ST_S2:
                begin
                    quad_reg  <= ph[31:30];
                    idx_reg   <= mpos[30:22];
                    frac_reg  <= mpos[21:0];
                    state_reg <= ST_S3;
                end
                ST_S3:
                begin
                    lo_reg    <= SINE_TAB[idx_reg];
                    state_reg <= ST_S4;
                end
                ST_S4:
                begin
                    acc_reg   <= sine_res;
                    pin_reg   <= sine_res;
                    mode_reg  <= MODE_LOW;
                    i_reg     <= '0;
                    addr_reg  <= gabc_pkg::ADDR_W'(gabc_pkg::LOW_BASE);
                    state_reg <= ST_RD;
                end
                ST_L1:
                begin
                    pin_reg   <= out_reg;
                    state_reg <= ST_L2;
                end
                ST_L2:
                begin
                    acc_reg <= l2_acc;
                    if (i_reg + 6'd1 == nl)
                    begin
                        mode_reg <= MODE_HIGH;
                        i_reg    <= '0;
                        addr_reg <= gabc_pkg::ADDR_W'(gabc_pkg::HIGH_BASE);
                        pin_reg  <= l2_acc;
                    end
                    else
                    begin
                        i_reg    <= i_reg + 6'd1;
                        addr_reg <= addr_reg + 1'b1;
                    end
                    state_reg <= ST_RD;
                end
                ST_O1: state_reg <= ST_O2;
                ST_O2:
                begin
                    // Wait here until the output register is free.
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= out_sat;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The memory address always stays inside the state memory.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (32'(addr_reg) < gabc_pkg::MEM_DEPTH))
        else $error("state memory address out of range");

    // A written section reads back as valid from then on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PG) |=> vld_reg[$past(addr_reg)])
        else $error("valid bit not set after write-back");

    // The band index never passes the last band.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (y_reg <= 4'(BAND_LAST)))
        else $error("band index out of range");

    // Leaving the output state always leaves a result waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_O2 && (!out_valid_reg || m_tready)) |=>
        (m_tvalid && state_reg == ST_IDLE))
        else $error("result not presented");

endmodule
